// ===== src/csrab_pkg.sv =====
// Package for the CSR adjacency builder: status and mode codes, sequencer states.
// Used by csr_adjacency_builder_top and the testbench; csrab_ram does not use it.
package csrab_pkg;

  localparam int unsigned MaxNodes = 256;
  localparam int unsigned MaxEdges = 1024;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_UNKNOWN   = 4'd1,
    ST_SELF      = 4'd2,
    ST_DUP       = 4'd3,
    ST_BUILT     = 4'd4,
    ST_FULL      = 4'd5,
    ST_NOT_BUILT = 4'd6,
    ST_RANGE     = 4'd7,
    ST_ABSENT    = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_BUILD = 3'd1,
    MODE_ROWS  = 3'd2,
    MODE_ENTRY = 3'd3,
    MODE_FIND  = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_CHK,
    S_CLR,
    S_CNT_RD,
    S_CNT_WR,
    S_SUM,
    S_SCAT_RD,
    S_SCAT_A,
    S_SCAT_B,
    S_ROW_RD,
    S_ROW_RD2,
    S_ENT_RD,
    S_FIND_RD,
    S_FIND_CHK,
    S_DONE
  } state_e;

endpackage

// ===== src/csrab_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module csrab_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/csr_adjacency_builder_top.sv =====
// CSR adjacency builder: request sequencer around edge, row and entry memories.
// Depends on csrab_pkg and csrab_ram.
//
// Usage:
//  - node_count_we_i/node_count_i write the node count register (idle only).
//  - Input channel (valid/ready) carries one request; output channel returns
//    one result per request, held in an output register until taken.
//  - in_ready_o is high only when the sequencer is idle and no result waits.
//  - Work per request, from the accepting edge to out_valid_o:
//      rejected request: goes straight to the done state
//      add edge: duplicate scan over the loaded edges, one edge read and compared at a time
//        (a duplicate ends the scan early)
//      build: clear MaxNodes+1 row slots, count both endpoints of each edge, prefix sum, scatter
//      read row bounds: two row reads; read entry: one entry read; find edge: two row reads,
//        then one entry read and compare per row entry scanned, ending at the row end if absent.
//    All work goes through one shared memory read port per store.
//  - The next request can be accepted in the cycle after the result is taken.
//  - Reset clears the edge count, built flag, node count and the sequencer;
//    memories need no clearing pass (the build sweep clears the row counts).
//  - A stalled receiver holds the result; no new request is taken meanwhile.
module csr_adjacency_builder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        node_count_we_i,
  input  logic [8:0]  node_count_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  node_a_i,
  input  logic [7:0]  node_b_i,
  input  logic [10:0] entry_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [9:0]  edge_id_o,
  output logic [7:0]  neighbor_o,
  output logic [11:0] row_begin_o,
  output logic [11:0] row_end_o
);

  localparam int unsigned MAX_NODES = csrab_pkg::MaxNodes;
  localparam int unsigned MAX_EDGES = csrab_pkg::MaxEdges;
  localparam int unsigned EW = $clog2(MAX_EDGES);
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned RD = MAX_NODES + 1;
  localparam int unsigned RW = $clog2(RD);
  localparam int unsigned AD = 2 * MAX_EDGES;
  localparam int unsigned AW = $clog2(AD);
  localparam int unsigned BW = $clog2(AD + 1);
  localparam int unsigned IW = (CW > RW + 1) ? CW : RW + 1;

  csrab_pkg::state_e state_q, state_d;
  logic [8:0]  nc_q;
  logic [CW-1:0] loaded_q, loaded_d;
  logic        built_q, built_d;
  logic [2:0]  mode_q;
  logic [7:0]  a_q, b_q;
  logic [10:0] idx_q;
  logic [IW-1:0] i_q, i_d;
  logic [BW-1:0] acc_q, acc_d, lim_q, lim_d;
  logic [3:0]  st_q, st_d;
  logic [9:0]  eid_q, eid_d;
  logic [7:0]  nbr_q, nbr_d;
  logic [11:0] rb_q, rb_d, re_q, re_d;
  logic        ov_q, ov_d;
  logic [8:0]  nc_use;

  // memory ports
  logic e_we; logic [EW-1:0] e_wa, e_ra; logic [15:0] e_wd, e_rd;
  logic r_we; logic [RW-1:0] r_wa, r_ra; logic [BW-1:0] r_wd, r_rd;
  logic f_we; logic [NW-1:0] f_wa, f_ra; logic [BW-1:0] f_wd, f_rd;
  logic j_we; logic [AW-1:0] j_wa, j_ra; logic [EW+7:0] j_wd, j_rd;

  csrab_ram #(.Width(16), .Depth(MAX_EDGES)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra), .rdata_o(e_rd));
  csrab_ram #(.Width(BW), .Depth(RD)) u_row (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd), .raddr_i(r_ra), .rdata_o(r_rd));
  csrab_ram #(.Width(BW), .Depth(MAX_NODES)) u_fill (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra), .rdata_o(f_rd));
  csrab_ram #(.Width(EW + 8), .Depth(AD)) u_adj (
    .clk_i, .we_i(j_we), .waddr_i(j_wa), .wdata_i(j_wd), .raddr_i(j_ra), .rdata_o(j_rd));

  assign nc_use = (nc_q > 9'(MAX_NODES)) ? 9'(MAX_NODES) : nc_q;
  assign in_ready_o = (state_q == csrab_pkg::S_IDLE) && !ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= csrab_pkg::S_IDLE;
      nc_q     <= '0;
      loaded_q <= '0;
      built_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      built_q  <= built_d;
      ov_q     <= ov_d;
      if (node_count_we_i) begin
        nc_q <= node_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      idx_q  <= entry_index_i;
    end
    i_q   <= i_d;
    acc_q <= acc_d;
    lim_q <= lim_d;
    st_q  <= st_d;
    eid_q <= eid_d;
    nbr_q <= nbr_d;
    rb_q  <= rb_d;
    re_q  <= re_d;
  end

  always_comb begin
    logic [7:0] ea, eb;
    state_d = state_q; loaded_d = loaded_q; built_d = built_q; ov_d = ov_q;
    i_d = i_q; acc_d = acc_q; lim_d = lim_q;
    st_d = st_q; eid_d = eid_q; nbr_d = nbr_q; rb_d = rb_q; re_d = re_q;
    e_we = 1'b0; e_wa = loaded_q[EW-1:0]; e_wd = {a_q, b_q}; e_ra = i_q[EW-1:0];
    r_we = 1'b0; r_wa = i_q[RW-1:0]; r_wd = '0; r_ra = i_q[RW-1:0];
    f_we = 1'b0; f_wa = i_q[NW-1:0]; f_wd = acc_q; f_ra = e_rd[15:8];
    j_we = 1'b0; j_wa = f_rd[AW-1:0]; j_wd = '0; j_ra = idx_q[AW-1:0];
    ea = e_rd[15:8]; eb = e_rd[7:0];
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      csrab_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          st_d = csrab_pkg::ST_OK; eid_d = '0; nbr_d = '0; rb_d = '0; re_d = '0;
          i_d = '0; acc_d = '0; lim_d = '0;
          state_d = csrab_pkg::S_DONE;
          case (mode_i)
            csrab_pkg::MODE_ADD: begin
              if (built_q) st_d = csrab_pkg::ST_BUILT;
              else if ({1'b0, node_a_i} >= nc_use || {1'b0, node_b_i} >= nc_use)
                st_d = csrab_pkg::ST_UNKNOWN;
              else if (node_a_i == node_b_i) st_d = csrab_pkg::ST_SELF;
              else state_d = csrab_pkg::S_DUP_RD;
            end
            csrab_pkg::MODE_BUILD: begin
              if (built_q) st_d = csrab_pkg::ST_BUILT;
              else state_d = csrab_pkg::S_CLR;
            end
            csrab_pkg::MODE_ROWS: begin
              if (!built_q) st_d = csrab_pkg::ST_NOT_BUILT;
              else if ({1'b0, node_a_i} >= nc_use) st_d = csrab_pkg::ST_UNKNOWN;
              else begin
                i_d = IW'(node_a_i);
                state_d = csrab_pkg::S_ROW_RD;
              end
            end
            csrab_pkg::MODE_ENTRY: begin
              if (!built_q) st_d = csrab_pkg::ST_NOT_BUILT;
              else if (12'(entry_index_i) >= 12'({loaded_q, 1'b0}))
                st_d = csrab_pkg::ST_RANGE;
              else state_d = csrab_pkg::S_ENT_RD;
            end
            csrab_pkg::MODE_FIND: begin
              if (!built_q) st_d = csrab_pkg::ST_NOT_BUILT;
              else if ({1'b0, node_a_i} >= nc_use || {1'b0, node_b_i} >= nc_use)
                st_d = csrab_pkg::ST_UNKNOWN;
              else begin
                i_d = IW'(node_a_i);
                state_d = csrab_pkg::S_ROW_RD;
              end
            end
            default: st_d = csrab_pkg::ST_RANGE;
          endcase
        end
      end
      csrab_pkg::S_DUP_RD: begin
        if (CW'(i_q) >= loaded_q) begin
          if (loaded_q >= CW'(MAX_EDGES)) st_d = csrab_pkg::ST_FULL;
          else begin
            e_we = 1'b1;
            eid_d = 10'(loaded_q);
            loaded_d = loaded_q + 1'b1;
          end
          state_d = csrab_pkg::S_DONE;
        end else begin
          state_d = csrab_pkg::S_DUP_CHK;
        end
      end
      csrab_pkg::S_DUP_CHK: begin
        if ((ea == a_q && eb == b_q) || (ea == b_q && eb == a_q)) begin
          st_d = csrab_pkg::ST_DUP;
          state_d = csrab_pkg::S_DONE;
        end else begin
          i_d = i_q + 1'b1;
          state_d = csrab_pkg::S_DUP_RD;
        end
      end
      csrab_pkg::S_CLR: begin
        r_we = 1'b1;
        if (i_q == IW'(MAX_NODES)) begin
          i_d = '0;
          state_d = csrab_pkg::S_CNT_RD;
        end else i_d = i_q + 1'b1;
      end
      csrab_pkg::S_CNT_RD: begin
        if (CW'(i_q) >= loaded_q) begin
          i_d = '0; acc_d = '0;
          state_d = csrab_pkg::S_SUM;
        end else state_d = csrab_pkg::S_CNT_WR;
      end
      csrab_pkg::S_CNT_WR: begin
        // count both endpoints into bound slot node+1; acc holds the phase
        e_ra = i_q[EW-1:0];
        r_ra = RW'(ea) + 1'b1;
        if (acc_q == '0) begin
          acc_d = BW'(2);
        end else if (acc_q == BW'(2)) begin
          r_we = 1'b1; r_wa = RW'(ea) + 1'b1; r_wd = r_rd + 1'b1;
          r_ra = RW'(eb) + 1'b1;
          acc_d = BW'(1);
        end else begin
          r_we = 1'b1; r_wa = RW'(eb) + 1'b1; r_wd = r_rd + 1'b1;
          acc_d = '0;
          i_d = i_q + 1'b1;
          state_d = csrab_pkg::S_CNT_RD;
        end
      end
      csrab_pkg::S_SUM: begin
        r_ra = i_q[RW-1:0];
        if (lim_q == '0) lim_d = BW'(1);
        else begin
          lim_d = '0;
          acc_d = acc_q + r_rd;
          r_we = 1'b1; r_wd = acc_q + r_rd;
          if (i_q < IW'(MAX_NODES)) begin
            f_we = 1'b1; f_wa = i_q[NW-1:0]; f_wd = acc_q + r_rd;
          end
          if (i_q == IW'(MAX_NODES)) begin
            i_d = '0; acc_d = '0;
            state_d = csrab_pkg::S_SCAT_RD;
          end else i_d = i_q + 1'b1;
        end
      end
      csrab_pkg::S_SCAT_RD: begin
        if (CW'(i_q) >= loaded_q) begin
          built_d = 1'b1;
          state_d = csrab_pkg::S_DONE;
        end else state_d = csrab_pkg::S_SCAT_A;
      end
      csrab_pkg::S_SCAT_A: begin
        if (lim_q == '0) begin
          f_ra = ea; lim_d = BW'(1);
        end else begin
          lim_d = '0;
          j_we = 1'b1; j_wa = f_rd[AW-1:0]; j_wd = {i_q[EW-1:0], eb};
          f_we = 1'b1; f_wa = ea; f_wd = f_rd + 1'b1;
          state_d = csrab_pkg::S_SCAT_B;
        end
      end
      csrab_pkg::S_SCAT_B: begin
        if (lim_q == '0) begin
          f_ra = eb; lim_d = BW'(1);
        end else begin
          lim_d = '0;
          j_we = 1'b1; j_wa = f_rd[AW-1:0]; j_wd = {i_q[EW-1:0], ea};
          f_we = 1'b1; f_wa = eb; f_wd = f_rd + 1'b1;
          i_d = i_q + 1'b1;
          state_d = csrab_pkg::S_SCAT_RD;
        end
      end
      csrab_pkg::S_ROW_RD: begin
        r_ra = i_q[RW-1:0];
        i_d = i_q + 1'b1;
        state_d = csrab_pkg::S_ROW_RD2;
      end
      csrab_pkg::S_ROW_RD2: begin
        r_ra = i_q[RW-1:0];
        if (lim_q == '0) begin
          acc_d = r_rd; lim_d = BW'(1);
        end else begin
          lim_d = '0;
          if (mode_q == csrab_pkg::MODE_ROWS) begin
            rb_d = 12'(acc_q); re_d = 12'(r_rd);
            state_d = csrab_pkg::S_DONE;
          end else begin
            lim_d = r_rd; i_d = '0;
            state_d = csrab_pkg::S_FIND_RD;
          end
        end
      end
      csrab_pkg::S_FIND_RD: begin
        j_ra = acc_q[AW-1:0];
        if (acc_q >= lim_q) begin
          st_d = csrab_pkg::ST_ABSENT;
          lim_d = '0;
          state_d = csrab_pkg::S_DONE;
        end else state_d = csrab_pkg::S_FIND_CHK;
      end
      csrab_pkg::S_FIND_CHK: begin
        if (j_rd[7:0] == b_q) begin
          eid_d = 10'(j_rd[EW+7:8]); nbr_d = b_q;
          lim_d = '0;
          state_d = csrab_pkg::S_DONE;
        end else begin
          acc_d = acc_q + 1'b1;
          state_d = csrab_pkg::S_FIND_RD;
        end
      end
      csrab_pkg::S_ENT_RD: begin
        if (lim_q == '0) lim_d = BW'(1);
        else begin
          lim_d = '0;
          eid_d = 10'(j_rd[EW+7:8]); nbr_d = j_rd[7:0];
          state_d = csrab_pkg::S_DONE;
        end
      end
      csrab_pkg::S_DONE: begin
        ov_d = 1'b1;
        lim_d = '0;
        state_d = csrab_pkg::S_IDLE;
        if (st_q != csrab_pkg::ST_OK) begin
          eid_d = '0; nbr_d = '0; rb_d = '0; re_d = '0;
        end
      end
      default: state_d = csrab_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign edge_id_o   = (st_q == csrab_pkg::ST_OK) ? eid_q : '0;
  assign neighbor_o  = (st_q == csrab_pkg::ST_OK) ? nbr_q : '0;
  assign row_begin_o = (st_q == csrab_pkg::ST_OK) ? rb_q : '0;
  assign row_end_o   = (st_q == csrab_pkg::ST_OK) ? re_q : '0;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != csrab_pkg::S_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_loaded_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= CW'(MAX_EDGES)) else $error("edge count overflow");
  a_built_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(built_q) |-> built_q) else $error("built flag dropped");

endmodule

// ===== tb/testbench.sv =====
// Testbench for csr_adjacency_builder_top: edge loading, one build, then row, entry and
// edge lookups, each result checked against an in-bench CSR predictor or a fixed expected status.
// Depends on csrab_pkg and the builder RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 2000000;
  localparam logic [2:0] ModeRsvdLo = 3'd5;
  localparam logic [2:0] ModeRsvdHi = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [10:0] idx;
  } req_t;

  typedef struct packed {
    csrab_pkg::status_e st;
    logic [9:0]  eid;
    logic [7:0]  nbr;
    logic [11:0] rb;
    logic [11:0] re;
  } adj_res_t;

  typedef struct {
    bit       cfg;
    logic [8:0] nodes;
    req_t     req;
    bit       fixed;
    csrab_pkg::status_e st;
    logic [9:0] eid;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        node_count_we_i = 1'b0;
  logic [8:0]  node_count_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  mode_i = '0;
  logic [7:0]  node_a_i = '0;
  logic [7:0]  node_b_i = '0;
  logic [10:0] entry_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  status_o;
  logic [9:0]  edge_id_o;
  logic [7:0]  neighbor_o;
  logic [11:0] row_begin_o;
  logic [11:0] row_end_o;

  csr_adjacency_builder_top dut (
    .clk_i, .rst_ni, .node_count_we_i, .node_count_i, .in_valid_i, .in_ready_o,
    .mode_i, .node_a_i, .node_b_i, .entry_index_i, .out_valid_o, .out_ready_i,
    .status_o, .edge_id_o, .neighbor_o, .row_begin_o, .row_end_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [8:0]  pred_nodes;
  logic [7:0]  pred_first [csrab_pkg::MaxEdges];
  logic [7:0]  pred_second [csrab_pkg::MaxEdges];
  int unsigned pred_loaded;
  bit          pred_built;
  int unsigned pred_bounds [csrab_pkg::MaxNodes + 1];
  logic [9:0]  pred_adj_eid [2 * csrab_pkg::MaxEdges];
  logic [7:0]  pred_adj_nbr [2 * csrab_pkg::MaxEdges];

  adj_res_t    pending_results [$];
  step_t       steps [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned results_seen;
  int unsigned requests_sent;
  bit          calm;

  function automatic void build_csr();
    int unsigned cur [csrab_pkg::MaxNodes];
    for (int i = 0; i <= csrab_pkg::MaxNodes; i++) pred_bounds[i] = 0;
    for (int i = 0; i < pred_loaded; i++) begin
      pred_bounds[pred_first[i] + 1]++;
      pred_bounds[pred_second[i] + 1]++;
    end
    for (int i = 1; i <= csrab_pkg::MaxNodes; i++) pred_bounds[i] += pred_bounds[i - 1];
    for (int i = 0; i < csrab_pkg::MaxNodes; i++) cur[i] = pred_bounds[i];
    for (int i = 0; i < pred_loaded; i++) begin
      pred_adj_eid[cur[pred_first[i]]] = 10'(i);
      pred_adj_nbr[cur[pred_first[i]]] = pred_second[i];
      cur[pred_first[i]]++;
      pred_adj_eid[cur[pred_second[i]]] = 10'(i);
      pred_adj_nbr[cur[pred_second[i]]] = pred_first[i];
      cur[pred_second[i]]++;
    end
  endfunction

  function automatic adj_res_t predict_adjacency(req_t r);
    adj_res_t    o;
    int unsigned nc;
    o = '0;
    o.st = csrab_pkg::ST_OK;
    nc = (pred_nodes > csrab_pkg::MaxNodes) ? csrab_pkg::MaxNodes : pred_nodes;
    case (r.mode)
      csrab_pkg::MODE_ADD: begin
        if (pred_built) o.st = csrab_pkg::ST_BUILT;
        else if (r.a >= nc || r.b >= nc) o.st = csrab_pkg::ST_UNKNOWN;
        else if (r.a == r.b) o.st = csrab_pkg::ST_SELF;
        else begin
          for (int i = 0; i < pred_loaded; i++) begin
            if ((pred_first[i] == r.a && pred_second[i] == r.b) ||
                (pred_first[i] == r.b && pred_second[i] == r.a)) begin
              o.st = csrab_pkg::ST_DUP;
              break;
            end
          end
          if (o.st == csrab_pkg::ST_OK) begin
            if (pred_loaded >= csrab_pkg::MaxEdges) o.st = csrab_pkg::ST_FULL;
            else begin
              pred_first[pred_loaded] = r.a;
              pred_second[pred_loaded] = r.b;
              o.eid = 10'(pred_loaded);
              pred_loaded++;
            end
          end
        end
      end
      csrab_pkg::MODE_BUILD: begin
        if (pred_built) o.st = csrab_pkg::ST_BUILT;
        else begin
          pred_built = 1'b1;
          build_csr();
        end
      end
      csrab_pkg::MODE_ROWS: begin
        if (!pred_built) o.st = csrab_pkg::ST_NOT_BUILT;
        else if (r.a >= nc) o.st = csrab_pkg::ST_UNKNOWN;
        else begin
          o.rb = 12'(pred_bounds[r.a]);
          o.re = 12'(pred_bounds[r.a + 1]);
        end
      end
      csrab_pkg::MODE_ENTRY: begin
        if (!pred_built) o.st = csrab_pkg::ST_NOT_BUILT;
        else if (r.idx >= 2 * pred_loaded) o.st = csrab_pkg::ST_RANGE;
        else begin
          o.eid = pred_adj_eid[r.idx];
          o.nbr = pred_adj_nbr[r.idx];
        end
      end
      csrab_pkg::MODE_FIND: begin
        if (!pred_built) o.st = csrab_pkg::ST_NOT_BUILT;
        else if (r.a >= nc || r.b >= nc) o.st = csrab_pkg::ST_UNKNOWN;
        else begin
          o.st = csrab_pkg::ST_ABSENT;
          for (int i = pred_bounds[r.a]; i < pred_bounds[r.a + 1]; i++) begin
            if (pred_adj_nbr[i] == r.b) begin
              o.st = csrab_pkg::ST_OK;
              o.eid = pred_adj_eid[i];
              o.nbr = r.b;
              break;
            end
          end
        end
      end
      default: o.st = csrab_pkg::ST_RANGE;
    endcase
    if (o.st != csrab_pkg::ST_OK) begin
      o.eid = '0;
      o.nbr = '0;
      o.rb = '0;
      o.re = '0;
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    if (errors <= 40)
      $display("mismatch result %0d %s: got %0d expected %0d", results_seen, field, got, want);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i)
    out_ready_i <= calm || ($urandom_range(99) >= 23);

  always @(posedge clk_i) begin
    adj_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) report_mismatch("unexpected", status_o, -1);
      else begin
        want = pending_results.pop_front();
        if (status_o != want.st) report_mismatch("status", status_o, want.st);
        if (edge_id_o != want.eid) report_mismatch("edge_id", edge_id_o, want.eid);
        if (neighbor_o != want.nbr) report_mismatch("neighbor", neighbor_o, want.nbr);
        if (row_begin_o != want.rb) report_mismatch("row_begin", row_begin_o, want.rb);
        if (row_end_o != want.re) report_mismatch("row_end", row_end_o, want.re);
      end
    end
  end

  task automatic send_request(req_t r, bit fixed, csrab_pkg::status_e st, logic [9:0] eid);
    adj_res_t predicted;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 23) @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= r.mode;
    node_a_i <= r.a;
    node_b_i <= r.b;
    entry_index_i <= r.idx;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_adjacency(r);
    if (fixed) begin
      predicted = '0;
      predicted.st = st;
      predicted.eid = eid;
    end
    pending_results.insert(pending_results.size(), predicted);
    requests_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_nodes(logic [8:0] value);
    drain();
    @(negedge clk_i);
    node_count_we_i <= 1'b1;
    node_count_i <= value;
    @(negedge clk_i);
    node_count_we_i <= 1'b0;
    pred_nodes = value;
  endtask

  task automatic run_steps();
    foreach (steps[i]) begin
      if (steps[i].cfg) write_nodes(steps[i].nodes);
      else send_request(steps[i].req, steps[i].fixed, steps[i].st, steps[i].eid);
    end
    steps.delete();
  endtask

  function automatic void clear_step(output step_t s);
    s.cfg = 1'b0;
    s.nodes = '0;
    s.req = '0;
    s.fixed = 1'b0;
    s.st = csrab_pkg::ST_OK;
    s.eid = '0;
  endfunction

  function automatic void add_cfg(logic [8:0] value);
    step_t s;
    clear_step(s);
    s.cfg = 1'b1;
    s.nodes = value;
    steps.insert(steps.size(), s);
  endfunction

  function automatic void add_req(logic [2:0] m, logic [7:0] a, logic [7:0] b,
                                  logic [10:0] idx, bit fixed = 1'b0,
                                  csrab_pkg::status_e st = csrab_pkg::ST_OK,
                                  logic [9:0] eid = '0);
    step_t s;
    clear_step(s);
    s.req = '{mode: m, a: a, b: b, idx: idx};
    s.fixed = fixed;
    s.st = st;
    s.eid = eid;
    steps.insert(steps.size(), s);
  endfunction

  function automatic req_t random_add(int unsigned span);
    req_t r;
    int unsigned k;
    r = '{mode: csrab_pkg::MODE_ADD, a: $urandom_range(span - 1), b: $urandom_range(span - 1),
          idx: $urandom_range(2047)};
    if (pred_loaded != 0 && $urandom_range(99) < 10) begin
      k = $urandom_range(pred_loaded - 1);
      r.a = $urandom_range(1) ? pred_first[k] : pred_second[k];
      r.b = (r.a == pred_first[k]) ? pred_second[k] : pred_first[k];
    end else if ($urandom_range(99) < 5) r.b = r.a;
    return r;
  endfunction

  function automatic req_t random_lookup();
    req_t        r;
    int unsigned pick;
    int unsigned k;
    r = '{mode: csrab_pkg::MODE_ROWS, a: $urandom, b: $urandom, idx: $urandom_range(2047)};
    pick = $urandom_range(99);
    if (pick < 30) r.mode = csrab_pkg::MODE_ROWS;
    else if (pick < 60) begin
      r.mode = csrab_pkg::MODE_ENTRY;
      if ($urandom_range(3) != 0) r.idx = $urandom_range(2 * pred_loaded - 1);
    end else if (pick < 92) begin
      r.mode = csrab_pkg::MODE_FIND;
      if ($urandom_range(1)) begin
        k = $urandom_range(pred_loaded - 1);
        r.a = $urandom_range(1) ? pred_first[k] : pred_second[k];
        r.b = (r.a == pred_first[k]) ? pred_second[k] : pred_first[k];
      end
    end else if (pick < 96) r.mode = $urandom_range(ModeRsvdHi, ModeRsvdLo);
    else r.mode = $urandom_range(1) ? csrab_pkg::MODE_ADD : csrab_pkg::MODE_BUILD;
    return r;
  endfunction

  initial begin
    req_t r;
    pred_nodes = '0;
    pred_loaded = 0;
    pred_built = 1'b0;
    errors = 0;
    cycles = 0;
    results_seen = 0;
    requests_sent = 0;
    calm = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_req(csrab_pkg::MODE_ADD, 8'd0, 8'd1, 11'd0, 1'b1, csrab_pkg::ST_UNKNOWN);
    add_req(csrab_pkg::MODE_ROWS, 8'd0, 8'd0, 11'd0, 1'b1, csrab_pkg::ST_NOT_BUILT);
    add_req(csrab_pkg::MODE_ENTRY, 8'd0, 8'd0, 11'd2047, 1'b1, csrab_pkg::ST_NOT_BUILT);
    add_req(csrab_pkg::MODE_FIND, 8'd0, 8'd1, 11'd0, 1'b1, csrab_pkg::ST_NOT_BUILT);
    add_req(ModeRsvdLo, 8'd255, 8'd255, 11'd2047, 1'b1, csrab_pkg::ST_RANGE);
    add_req(ModeRsvdHi, 8'd0, 8'd0, 11'd0, 1'b1, csrab_pkg::ST_RANGE);
    add_cfg(9'd511);
    add_req(csrab_pkg::MODE_ADD, 8'd0, 8'd255, 11'd0, 1'b1, csrab_pkg::ST_OK, 10'd0);
    add_req(csrab_pkg::MODE_ADD, 8'd255, 8'd0, 11'd0, 1'b1, csrab_pkg::ST_DUP);
    add_req(csrab_pkg::MODE_ADD, 8'd3, 8'd3, 11'd0, 1'b1, csrab_pkg::ST_SELF);
    add_req(csrab_pkg::MODE_ADD, 8'd255, 8'd254, 11'd0, 1'b1, csrab_pkg::ST_OK, 10'd1);
    add_cfg(9'd2);
    add_req(csrab_pkg::MODE_ADD, 8'd0, 8'd1, 11'd0, 1'b1, csrab_pkg::ST_OK, 10'd2);
    add_req(csrab_pkg::MODE_ADD, 8'd1, 8'd0, 11'd0, 1'b1, csrab_pkg::ST_DUP);
    add_req(csrab_pkg::MODE_ADD, 8'd0, 8'd2, 11'd0, 1'b1, csrab_pkg::ST_UNKNOWN);
    add_req(csrab_pkg::MODE_ADD, 8'd2, 8'd1, 11'd0);
    run_steps();

    write_nodes(9'd256);
    for (int i = 0; i < 200; i++) begin
      calm = (i >= 60 && i < 140);
      send_request(random_add(256), 1'b0, csrab_pkg::ST_OK, '0);
    end
    calm = 1'b0;
    write_nodes(9'd200);
    for (int i = 0; i < 120; i++) send_request(random_add(256), 1'b0, csrab_pkg::ST_OK, '0);

    add_req(csrab_pkg::MODE_BUILD, 8'd0, 8'd0, 11'd0);
    add_req(csrab_pkg::MODE_BUILD, 8'd0, 8'd0, 11'd0, 1'b1, csrab_pkg::ST_BUILT);
    add_req(csrab_pkg::MODE_ADD, 8'd5, 8'd9, 11'd0, 1'b1, csrab_pkg::ST_BUILT);
    add_cfg(9'd256);
    add_req(csrab_pkg::MODE_ROWS, 8'd255, 8'd0, 11'd0);
    add_req(csrab_pkg::MODE_ROWS, 8'd0, 8'd0, 11'd0);
    add_req(csrab_pkg::MODE_ENTRY, 8'd0, 8'd0, 11'd2047, 1'b1, csrab_pkg::ST_RANGE);
    add_req(csrab_pkg::MODE_ENTRY, 8'd0, 8'd0, 11'd0);
    add_req(csrab_pkg::MODE_FIND, 8'd0, 8'd0, 11'd0, 1'b1, csrab_pkg::ST_ABSENT);
    add_req(csrab_pkg::MODE_FIND, 8'd255, 8'd0, 11'd0);
    run_steps();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_nodes(9'd256);
        1: write_nodes(9'd511);
        2: write_nodes(9'd100);
        3: write_nodes(9'd0);
        default: write_nodes(9'd256);
      endcase
      for (int i = 0; i < ((p == 3) ? 20 : 60); i++) begin
        r = random_lookup();
        send_request(r, 1'b0, csrab_pkg::ST_OK, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests, %0d results, %0d edges loaded before the build,",
             requests_sent, results_seen, pred_loaded);
    $display("node counts from 0 to 511, row, entry and edge lookups after the build");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/csrab_pkg.sv
src/csrab_ram.sv
src/csr_adjacency_builder_top.sv
tb/testbench.sv
